>>> src/vrefr_pkg.sv
`timescale 1ns / 1ps

package vrefr_pkg;

  // Integer square root: radicand padded to an even width, two bits per step.
  localparam int unsigned RAD_W       = 54;
  localparam int unsigned ROOT_W      = RAD_W / 2;
  localparam int unsigned REM_W       = ROOT_W + 2;
  localparam int unsigned SQRT_STEPS  = 3;
  localparam int unsigned SQRT_STAGES = ROOT_W / SQRT_STEPS;

  // Stages ahead of the root, and behind it.
  localparam int unsigned PRE_STAGES  = 6;
  localparam int unsigned POST_STAGES = 3;
  localparam int unsigned PIPE_LAT    = PRE_STAGES + SQRT_STAGES + POST_STAGES;

  // Fixed-point constants.
  localparam logic [28:0] ONE_Q28 = 29'd1 << 28;
  localparam logic [60:0] ONE_Q52 = 61'd1 << 52;
  localparam logic [15:0] ONE_Q12 = 16'd1 << 12;

  // Fields carried alongside the datapath until the final combine.
  typedef struct packed {
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic [2:0][32:0] veta;
    logic [15:0]      eta;
  } side_t;

endpackage

>>> src/vrefr_isqrt.sv
`timescale 1ns / 1ps

module vrefr_isqrt import vrefr_pkg::*; (
  input  logic              clk_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]  rad_w  [SQRT_STAGES+1];
  logic [REM_W-1:0]  rem_w  [SQRT_STAGES+1];
  logic [ROOT_W-1:0] root_w [SQRT_STAGES+1];

  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  assign rad_w[0]  = rad_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [RAD_W-1:0]  rad_d;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    // Restoring recurrence: bring down two radicand bits, try 4q+1.
    always_comb begin
      logic [REM_W+1:0] t;
      logic [REM_W+1:0] trial;
      rad_d  = rad_w[s];
      rem_d  = rem_w[s];
      root_d = root_w[s];
      for (int j = 0; j < SQRT_STEPS; j++) begin
        t     = {rem_d, rad_d[RAD_W-1 -: 2]};
        trial = {2'b00, root_d, 2'b01};
        if (t >= trial) begin
          rem_d  = REM_W'(t - trial);
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = t[REM_W-1:0];
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
        rad_d = rad_d << 2;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_d;
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
    end

    assign rad_w[s+1]  = rad_q[s];
    assign rem_w[s+1]  = rem_q[s];
    assign root_w[s+1] = root_q[s];
  end

  assign root_o = root_w[SQRT_STAGES];

endmodule

>>> src/vector_refract.sv
`timescale 1ns / 1ps

// Snell refraction of a direction vector at a surface, fixed point.
// Input beat: incident_x/y/z_i and normal_x/y/z_i in signed Q1.14, index_ratio_i
// (eta) in unsigned Q4.12. A beat is taken on every rising edge where start is
// high and busy is low; busy is held low, so a new beat may enter every cycle.
// Result beat: out_x/y/z_o in saturated Q1.14 plus total_reflection_o, shown for
// exactly one cycle with done_o high. The receiver has no way to stall, so no
// backpressure exists and nothing is ever held or dropped.
// Throughput is one beat per cycle. The pipeline length is set by six stages
// of products, rounding and the eta^2 multiply, nine stages of the integer
// square root (three result bits per stage over 27 bits), then three stages
// forming k, the n*k products and the final round and saturate.
// On total internal reflection the incident vector comes out unchanged.
// Reset clears the valid bits only; payload registers are left as they are,
// and no done_o is raised for beats started before reset.

module vector_refract import vrefr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] incident_x_i,
  input  logic [15:0] incident_y_i,
  input  logic [15:0] incident_z_i,
  input  logic [15:0] normal_x_i,
  input  logic [15:0] normal_y_i,
  input  logic [15:0] normal_z_i,
  input  logic [15:0] index_ratio_i,
  output logic        done_o,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [15:0] out_z_o,
  output logic        total_reflection_o
);

  // Never back off the sender: the pipe takes a beat every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // Stage 1: dot products, v*eta, eta^2.
  side_t                    side_d, side1_q;
  logic [2:0][31:0]         prod_d, prod1_q;
  logic [31:0]              eta2_d, eta2_1_q;
  logic                     val1_q;

  always_comb begin
    logic [2:0][15:0] vin;
    logic [2:0][15:0] nin;
    vin = {incident_z_i, incident_y_i, incident_x_i};
    nin = {normal_z_i, normal_y_i, normal_x_i};
    side_d.v   = vin;
    side_d.n   = nin;
    side_d.eta = index_ratio_i;
    for (int i = 0; i < 3; i++) begin
      prod_d[i]      = $signed(vin[i]) * $signed(nin[i]);
      side_d.veta[i] = $signed(vin[i]) * $signed({1'b0, index_ratio_i});
    end
    eta2_d = index_ratio_i * index_ratio_i;
  end

  always_ff @(posedge clk_i) begin
    side1_q  <= side_d;
    prod1_q  <= prod_d;
    eta2_1_q <= eta2_d;
  end

  // Stage 2: sum and round cos to Q.14.
  side_t              side2_q;
  logic signed [18:0] cos14_d, cos2_q;
  logic [31:0]        eta2_2_q;
  logic               val2_q;

  always_comb begin
    logic signed [33:0] sum;
    sum = 34'($signed(prod1_q[0])) + 34'($signed(prod1_q[1]))
        + 34'($signed(prod1_q[2])) + 34'sd8192;
    cos14_d = sum[32:14];
  end

  always_ff @(posedge clk_i) begin
    side2_q  <= side1_q;
    cos2_q   <= cos14_d;
    eta2_2_q <= eta2_1_q;
  end

  // Stage 3: cos^2 and cos*eta.
  side_t              side3_q;
  logic [35:0]        sq_d, sq3_q;
  logic signed [35:0] coseta_d, coseta3_q;
  logic [31:0]        eta2_3_q;
  logic               val3_q;

  always_comb begin
    logic signed [37:0] sqw;
    sqw      = cos2_q * cos2_q;
    sq_d     = sqw[35:0];
    coseta_d = cos2_q * $signed({1'b0, side2_q.eta});
  end

  always_ff @(posedge clk_i) begin
    side3_q   <= side2_q;
    sq3_q     <= sq_d;
    coseta3_q <= coseta_d;
    eta2_3_q  <= eta2_2_q;
  end

  // Stage 4: sin^2 clamped at zero.
  side_t              side4_q;
  logic [28:0]        sin2_d, sin2_4_q;
  logic signed [35:0] coseta4_q;
  logic [31:0]        eta2_4_q;
  logic               val4_q;

  always_comb begin
    logic signed [36:0] diff;
    diff   = $signed({8'd0, ONE_Q28}) - $signed({1'b0, sq3_q});
    sin2_d = diff[36] ? '0 : diff[28:0];
  end

  always_ff @(posedge clk_i) begin
    side4_q   <= side3_q;
    sin2_4_q  <= sin2_d;
    coseta4_q <= coseta3_q;
    eta2_4_q  <= eta2_3_q;
  end

  // Stage 5: sin^2 of the transmitted ray.
  side_t              side5_q;
  logic [60:0]        sin2t_d, sin2t5_q;
  logic signed [35:0] coseta5_q;
  logic               val5_q;

  assign sin2t_d = 61'(sin2_4_q * eta2_4_q);

  always_ff @(posedge clk_i) begin
    side5_q   <= side4_q;
    sin2t5_q  <= sin2t_d;
    coseta5_q <= coseta4_q;
  end

  // Stage 6: reflection test and square-root radicand.
  side_t              side6_q;
  logic               tir_d, tir6_q;
  logic [RAD_W-1:0]   rad_d, rad6_q;
  logic signed [35:0] coseta6_q;
  logic               val6_q;

  always_comb begin
    logic [60:0] rem;
    tir_d = sin2t5_q > ONE_Q52;
    rem   = ONE_Q52 - sin2t5_q;
    rad_d = tir_d ? '0 : RAD_W'(rem[52:0]);
  end

  always_ff @(posedge clk_i) begin
    side6_q   <= side5_q;
    tir6_q    <= tir_d;
    rad6_q    <= rad_d;
    coseta6_q <= coseta5_q;
  end

  // Square root; side fields ride a matching delay line.
  logic [ROOT_W-1:0]  cost;
  side_t              sdly_q   [SQRT_STAGES];
  logic               tdly_q   [SQRT_STAGES];
  logic signed [35:0] cdly_q   [SQRT_STAGES];
  logic               vdly_q   [SQRT_STAGES];

  vrefr_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad6_q),
    .root_o (cost)
  );

  always_ff @(posedge clk_i) begin
    sdly_q[0] <= side6_q;
    tdly_q[0] <= tir6_q;
    cdly_q[0] <= coseta6_q;
    for (int s = 1; s < SQRT_STAGES; s++) begin
      sdly_q[s] <= sdly_q[s-1];
      tdly_q[s] <= tdly_q[s-1];
      cdly_q[s] <= cdly_q[s-1];
    end
  end

  // Stage 7: k = cos*eta - cos_t.
  side_t              side7_q;
  logic signed [35:0] k_d, k7_q;
  logic               tir7_q;
  logic               val7_q;

  assign k_d = cdly_q[SQRT_STAGES-1] - $signed({9'd0, cost});

  always_ff @(posedge clk_i) begin
    side7_q <= sdly_q[SQRT_STAGES-1];
    tir7_q  <= tdly_q[SQRT_STAGES-1];
    k7_q    <= k_d;
  end

  // Stage 8: n*k per lane.
  side_t            side8_q;
  logic [2:0][51:0] nk_d, nk8_q;
  logic             tir8_q;
  logic             val8_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nk_d[i] = $signed(side7_q.n[i]) * k7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side8_q <= side7_q;
    tir8_q  <= tir7_q;
    nk8_q   <= nk_d;
  end

  // Stage 9: combine, round to Q.14, saturate, or pass v on reflection.
  logic [2:0][15:0] out_d, out_q;
  logic             tir_q;
  logic             val_q;

  always_comb begin
    logic signed [53:0] acc;
    logic signed [27:0] rs;
    for (int i = 0; i < 3; i++) begin
      acc = 54'($signed(nk8_q[i])) - (54'($signed(side8_q.veta[i])) <<< 14)
          + 54'sd33554432;
      rs  = acc[53:26];
      if (tir8_q) begin
        out_d[i] = side8_q.v[i];
      end else if (rs > 28'sd32767) begin
        out_d[i] = 16'h7fff;
      end else if (rs < -28'sd32768) begin
        out_d[i] = 16'h8000;
      end else begin
        out_d[i] = rs[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    tir_q <= tir8_q;
  end

  // Valid bits: advance with the data, clear on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val1_q <= 1'b0;
      val2_q <= 1'b0;
      val3_q <= 1'b0;
      val4_q <= 1'b0;
      val5_q <= 1'b0;
      val6_q <= 1'b0;
      for (int s = 0; s < SQRT_STAGES; s++) vdly_q[s] <= 1'b0;
      val7_q <= 1'b0;
      val8_q <= 1'b0;
      val_q  <= 1'b0;
    end else begin
      val1_q <= accept;
      val2_q <= val1_q;
      val3_q <= val2_q;
      val4_q <= val3_q;
      val5_q <= val4_q;
      val6_q <= val5_q;
      vdly_q[0] <= val6_q;
      for (int s = 1; s < SQRT_STAGES; s++) vdly_q[s] <= vdly_q[s-1];
      val7_q <= vdly_q[SQRT_STAGES-1];
      val8_q <= val7_q;
      val_q  <= val8_q;
    end
  end

  assign done_o             = val_q;
  assign out_x_o            = out_q[0];
  assign out_y_o            = out_q[1];
  assign out_z_o            = out_q[2];
  assign total_reflection_o = tir_q;

  // A result beat always traces back to an accepted input beat.
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_LAT))
    else $error("result beat without a matching input beat");

  // On reflection the incident vector comes back untouched.
  a_tir_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && total_reflection_o |->
      out_x_o == $past(incident_x_i, PIPE_LAT) &&
      out_y_o == $past(incident_y_i, PIPE_LAT) &&
      out_z_o == $past(incident_z_i, PIPE_LAT))
    else $error("reflected beat does not return the incident vector");

  // Reflection needs eta above one, since sin^2 never exceeds one.
  a_tir_needs_eta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && total_reflection_o |-> $past(index_ratio_i, PIPE_LAT) > ONE_Q12)
    else $error("reflection flagged with eta not above one");

endmodule

>>> bench/tb_vector_refract.sv
`timescale 1ns / 1ps

module tb_vector_refract;
  import vrefr_pkg::*;

  typedef struct {
    logic [15:0] x, y, z;
    logic        tir;
  } refr_beat_t;

  // Holds the refraction results still owed by the block, oldest first.
  class refract_board;
    refr_beat_t owed[$];
    int         errors;

    // Round to nearest, halves toward +inf, by an arithmetic shift.
    function automatic longint rnd_shift(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned a);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > a) b = b >> 2;
      while (b != 0) begin
        if (a >= r + b) begin
          a = a - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic logic [15:0] clamp_q14(longint x);
      if (x > 32767) return 16'h7fff;
      if (x < -32768) return 16'h8000;
      return x[15:0];
    endfunction

    // Compute the expected refraction for an accepted beat and queue it.
    function void note_incident(logic [2:0][15:0] v, logic [2:0][15:0] n,
                                logic [15:0] eta);
      longint sv[3], sn[3], e, cp, c14, s2, k, acc;
      longint unsigned s2t, ct;
      refr_beat_t r;
      e = longint'(eta);
      for (int i = 0; i < 3; i++) begin
        sv[i] = longint'($signed(v[i]));
        sn[i] = longint'($signed(n[i]));
      end
      cp = sv[0]*sn[0] + sv[1]*sn[1] + sv[2]*sn[2];
      c14 = rnd_shift(cp, 14);
      s2 = (longint'(1) << 28) - c14*c14;
      if (s2 < 0) s2 = 0;
      s2t = longint'(s2) * (e*e);
      if (s2t > (longint'(1) << 52)) begin
        r = '{v[0], v[1], v[2], 1'b1};
      end else begin
        ct = int_sqrt((longint'(1) << 52) - s2t);
        k = c14*e - longint'(ct);
        acc = -(sv[0]*e*16384) + sn[0]*k; r.x = clamp_q14(rnd_shift(acc, 26));
        acc = -(sv[1]*e*16384) + sn[1]*k; r.y = clamp_q14(rnd_shift(acc, 26));
        acc = -(sv[2]*e*16384) + sn[2]*k; r.z = clamp_q14(rnd_shift(acc, 26));
        r.tir = 1'b0;
      end
      owed.push_back(r);
    endfunction

    function void check_refracted(refr_beat_t got);
      refr_beat_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h tir=%b", $time,
                 got.x, got.y, got.z, got.tir);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: out_x expected %h actual %h", $time, want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: out_y expected %h actual %h", $time, want.y, got.y); errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: out_z expected %h actual %h", $time, want.z, got.z); errors++;
      end
      if (got.tir !== want.tir) begin
        $display("%0t: total_reflection expected %b actual %b", $time,
                 want.tir, got.tir);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni, start, busy, done_o, total_reflection_o;
  logic [15:0] incident_x_i, incident_y_i, incident_z_i;
  logic [15:0] normal_x_i, normal_y_i, normal_z_i, index_ratio_i;
  logic [15:0] out_x_o, out_y_o, out_z_o;

  refract_board board = new();
  longint       cycles = 0;
  localparam longint CYCLE_LIMIT = 200000;

  vector_refract dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sample results at the edge that ends the strobe cycle.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o === 1'b1)
      board.check_refracted('{out_x_o, out_y_o, out_z_o, total_reflection_o});
  end

  // Kill a hung run.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb_vector_refract failed");
    $finish;
  end

  // Drive one beat, hold start until taken, then idle a random gap, sometimes none.
  task automatic send_beat(logic [15:0] vx, vy, vz, nx, ny, nz, eta);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    start         <= 1'b1;
    incident_x_i  <= vx; incident_y_i <= vy; incident_z_i <= vz;
    normal_x_i    <= nx; normal_y_i   <= ny; normal_z_i   <= nz;
    index_ratio_i <= eta;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_incident('{vz, vy, vx}, '{nz, ny, nx}, eta);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Draw one vector component; mostly within +-1.0 in Q1.14, sometimes raw noise.
  function automatic logic [15:0] comp(bit noise);
    if (noise) return 16'($urandom());
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic send_random();
    bit noise;
    logic [15:0] eta;
    noise = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 3))
      0: eta = 16'($urandom());
      1: eta = 16'($urandom_range(2048, 8192));
      default: eta = 16'($urandom_range(3000, 6000));
    endcase
    send_beat(comp(noise), comp(noise), comp(noise),
              comp(noise), comp(noise), comp(noise), eta);
  endtask

  initial begin
    rst_ni = 1'b0; start = 1'b0;
    incident_x_i = '0; incident_y_i = '0; incident_z_i = '0;
    normal_x_i = '0; normal_y_i = '0; normal_z_i = '0; index_ratio_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero eta, grazing and critical cases.
    send_beat(16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000,
              ONE_Q12);                                            // head-on, eta 1
    send_beat(16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, ONE_Q12);
    send_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
              16'h1001);                                           // grazing, reflects
    send_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
              ONE_Q12);                                            // sin2t exactly one
    send_beat(16'h2d41, 16'h2d41, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h1800);
    send_beat(16'h1000, 16'h2000, 16'h3000, 16'h0000, 16'h0000, 16'hc000,
              16'h0000);                                           // eta zero
    send_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
    send_beat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0001);
    send_beat(16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h8000, 16'h0001, 16'h8000);
    send_beat(16'h1234, 16'hfedc, 16'h2000, 16'h3000, 16'h0100, 16'h0000, 16'h0800);
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(16'h3000, 16'h2000, 16'h0000, 16'h0000, 16'h2000, 16'h2000, 16'h2000);

    // Pause until the pipeline has drained once.
    start <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    @(posedge clk_i);

    for (int i = 0; i < 1000; i++) send_random();
    start <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("tb_vector_refract passed");
    else
      $display("tb_vector_refract failed");
    $finish;
  end
endmodule
